// ===== rtl/core/vts_pkg.sv =====
package vts_pkg;

    localparam int SIZE_W = 12;
    localparam int TILE_W = 11;
    localparam int X_W    = 13;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [SIZE_W-1:0] DEVICE_WIDTH_RST  = 12'd640;
    localparam logic [SIZE_W-1:0] DEVICE_HEIGHT_RST = 12'd480;
    localparam logic [TILE_W-1:0] TILE_WIDTH_RST    = 11'd32;
    localparam logic [TILE_W-1:0] TILE_HEIGHT_RST   = 11'd32;

    typedef enum logic [2:0] {
        REG_DEVICE_OPEN   = 3'd0,
        REG_DEVICE_WIDTH  = 3'd1,
        REG_DEVICE_HEIGHT = 3'd2,
        REG_TILE_WIDTH    = 3'd3,
        REG_TILE_HEIGHT   = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic              open;
        logic [SIZE_W-1:0] lim_x;
        logic [SIZE_W-1:0] lim_y;
        logic [TILE_W-1:0] tile_x;
        logic [TILE_W-1:0] tile_y;
    } cfg_t;

endpackage

// ===== rtl/core/vts_regs.sv =====
module vts_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vts_pkg::ADDR_W-1:0]  paddr,
    input  logic [vts_pkg::DATA_W-1:0]  pwdata,
    output logic [vts_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output vts_pkg::cfg_t               cfg
);

    logic                          device_open_reg;
    logic [vts_pkg::SIZE_W-1:0]    device_width_reg;
    logic [vts_pkg::SIZE_W-1:0]    device_height_reg;
    logic [vts_pkg::TILE_W-1:0]    tile_width_reg;
    logic [vts_pkg::TILE_W-1:0]    tile_height_reg;
    logic                          wr_en;
    vts_pkg::reg_idx_t             idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = vts_pkg::reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_open_reg   <= 1'b0;
            device_width_reg  <= vts_pkg::DEVICE_WIDTH_RST;
            device_height_reg <= vts_pkg::DEVICE_HEIGHT_RST;
            tile_width_reg    <= vts_pkg::TILE_WIDTH_RST;
            tile_height_reg   <= vts_pkg::TILE_HEIGHT_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                vts_pkg::REG_DEVICE_OPEN:   device_open_reg   <= pwdata[0];
                vts_pkg::REG_DEVICE_WIDTH:  device_width_reg  <= pwdata[vts_pkg::SIZE_W-1:0];
                vts_pkg::REG_DEVICE_HEIGHT: device_height_reg <= pwdata[vts_pkg::SIZE_W-1:0];
                vts_pkg::REG_TILE_WIDTH:    tile_width_reg    <= pwdata[vts_pkg::TILE_W-1:0];
                vts_pkg::REG_TILE_HEIGHT:   tile_height_reg   <= pwdata[vts_pkg::TILE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            vts_pkg::REG_DEVICE_OPEN:   prdata = vts_pkg::DATA_W'(device_open_reg);
            vts_pkg::REG_DEVICE_WIDTH:  prdata = vts_pkg::DATA_W'(device_width_reg);
            vts_pkg::REG_DEVICE_HEIGHT: prdata = vts_pkg::DATA_W'(device_height_reg);
            vts_pkg::REG_TILE_WIDTH:    prdata = vts_pkg::DATA_W'(tile_width_reg);
            vts_pkg::REG_TILE_HEIGHT:   prdata = vts_pkg::DATA_W'(tile_height_reg);
            default:                    prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.open   = device_open_reg;
        cfg.lim_x  = (device_width_reg == '0) ? '0 : device_width_reg - 1'b1;
        cfg.lim_y  = (device_height_reg == '0) ? '0 : device_height_reg - 1'b1;
        cfg.tile_x = (tile_width_reg == '0) ? vts_pkg::TILE_W'(1) : tile_width_reg;
        cfg.tile_y = (tile_height_reg == '0) ? vts_pkg::TILE_W'(1) : tile_height_reg;
    end

endmodule

// ===== rtl/core/vts_prep.sv =====
module vts_prep #(
    parameter int COORD_BITS = 16
) (
    input  logic                           clk,
    input  logic signed [COORD_BITS-1:0]   lo_in,
    input  logic signed [COORD_BITS-1:0]   hi_in,
    input  logic [vts_pkg::SIZE_W-1:0]     lim,
    input  logic [vts_pkg::TILE_W-1:0]     tile,
    output logic [vts_pkg::X_W-1:0]        lo_x,
    output logic [vts_pkg::X_W-1:0]        hi_x
);

    localparam int CMP_W = ((COORD_BITS > vts_pkg::SIZE_W) ? COORD_BITS : vts_pkg::SIZE_W) + 1;

    logic [vts_pkg::SIZE_W-1:0] a;
    logic [vts_pkg::SIZE_W-1:0] b;
    logic [vts_pkg::SIZE_W-1:0] mn;
    logic [vts_pkg::SIZE_W-1:0] mx;
    logic [vts_pkg::TILE_W-1:0] half;
    logic [vts_pkg::X_W-1:0]    lo_x_next;
    logic [vts_pkg::X_W-1:0]    hi_x_next;
    logic [vts_pkg::X_W-1:0]    lo_x_reg;
    logic [vts_pkg::X_W-1:0]    hi_x_reg;

    function automatic logic [vts_pkg::SIZE_W-1:0] clamp_coord(
        input logic signed [COORD_BITS-1:0] v,
        input logic [vts_pkg::SIZE_W-1:0]   hi
    );
        logic signed [CMP_W-1:0] ve;
        logic signed [CMP_W-1:0] he;
        ve = CMP_W'(v);
        he = signed'(CMP_W'(hi));
        if (ve < 0)
            return '0;
        else if (ve > he)
            return hi;
        else
            return ve[vts_pkg::SIZE_W-1:0];
    endfunction

    always_comb
    begin
        a         = clamp_coord(lo_in, lim);
        b         = clamp_coord(hi_in, lim);
        mn        = (a > b) ? b : a;
        mx        = (a > b) ? a : b;
        half      = {1'b0, tile[vts_pkg::TILE_W-1:1]};
        lo_x_next = vts_pkg::X_W'(mn) + vts_pkg::X_W'(half);
        hi_x_next = vts_pkg::X_W'(mx) + vts_pkg::X_W'(half) + vts_pkg::X_W'(1);
    end

    always_ff @(posedge clk)
    begin
        lo_x_reg <= lo_x_next;
        hi_x_reg <= hi_x_next;
    end

    assign lo_x = lo_x_reg;
    assign hi_x = hi_x_reg;

endmodule

// ===== rtl/core/vts_div.sv =====
module vts_div (
    input  logic                       clk,
    input  logic [vts_pkg::X_W-1:0]    dividend,
    input  logic [vts_pkg::TILE_W-1:0] divisor,
    output logic [vts_pkg::X_W-1:0]    quotient
);

    localparam int N = vts_pkg::X_W;
    localparam int W = vts_pkg::TILE_W;

    logic [W-1:0] rem_reg [N];
    logic [N-1:0] num_reg [N];
    logic [N-1:0] quo_reg [N];

    genvar s;
    generate
        for (s = 0; s < N; s++)
        begin : g_stage
            logic [W-1:0] rem_in;
            logic [N-1:0] num_in;
            logic [N-1:0] quo_in;
            logic [W:0]   trial;
            logic [W:0]   diff;
            logic         ge;

            if (s == 0)
            begin : g_first
                assign rem_in = '0;
                assign num_in = dividend;
                assign quo_in = '0;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[s-1];
                assign num_in = num_reg[s-1];
                assign quo_in = quo_reg[s-1];
            end

            always_comb
            begin
                trial = {rem_in, num_in[N-1]};
                diff  = trial - {1'b0, divisor};
                ge    = (trial >= {1'b0, divisor});
            end

            always_ff @(posedge clk)
            begin
                rem_reg[s] <= ge ? diff[W-1:0] : trial[W-1:0];
                num_reg[s] <= {num_in[N-2:0], 1'b0};
                quo_reg[s] <= {quo_in[N-2:0], ge};
            end
        end
    endgenerate

    assign quotient = quo_reg[N-1];

endmodule

// ===== rtl/core/vts_snap.sv =====
module vts_snap (
    input  logic                       clk,
    input  logic [vts_pkg::X_W-1:0]    q_lo,
    input  logic [vts_pkg::X_W-1:0]    q_hi,
    input  logic [vts_pkg::TILE_W-1:0] tile,
    input  logic [vts_pkg::SIZE_W-1:0] lim,
    output logic [vts_pkg::SIZE_W-1:0] lo_res,
    output logic [vts_pkg::SIZE_W-1:0] hi_res
);

    localparam int P_W = vts_pkg::X_W + vts_pkg::TILE_W;

    logic [P_W-1:0]              prod_lo;
    logic [P_W-1:0]              prod_hi;
    logic [vts_pkg::X_W-1:0]     p_lo_reg;
    logic [vts_pkg::X_W-1:0]     p_hi_reg;
    logic [vts_pkg::X_W-1:0]     hi_m1;
    logic [vts_pkg::X_W-1:0]     lim_x;

    assign prod_lo = P_W'(q_lo) * P_W'(tile);
    assign prod_hi = P_W'(q_hi) * P_W'(tile);

    always_ff @(posedge clk)
    begin
        p_lo_reg <= prod_lo[vts_pkg::X_W-1:0];
        p_hi_reg <= prod_hi[vts_pkg::X_W-1:0];
    end

    always_comb
    begin
        lim_x  = vts_pkg::X_W'(lim);
        hi_m1  = p_hi_reg - vts_pkg::X_W'(1);
        lo_res = (p_lo_reg > lim_x) ? lim : p_lo_reg[vts_pkg::SIZE_W-1:0];
        if (p_hi_reg == '0)
            hi_res = '0;
        else if (hi_m1 > lim_x)
            hi_res = lim;
        else
            hi_res = hi_m1[vts_pkg::SIZE_W-1:0];
    end

endmodule

// ===== rtl/core/viewport_tile_snap_top.sv =====
// Snaps a viewport rectangle to the tile grid of the open device. A rectangle is
// taken on any cycle with start high (busy never rises), one per clock, and its
// result appears as a single-cycle done pulse with out_* and status; the receiver
// cannot hold it, so capture it on that cycle. The pipeline is one clamp/swap
// stage, thirteen divider stages that each resolve one quotient bit of the
// division by the tile size, one multiply stage and one output stage. With
// device_open low the request is echoed and status is 1. The user must configure
// via the APB port only while no transaction is in flight; the block does not check.
module viewport_tile_snap_top #(
    parameter int COORD_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vts_pkg::ADDR_W-1:0]    paddr,
    input  logic [vts_pkg::DATA_W-1:0]    pwdata,
    output logic [vts_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_BITS-1:0]  req_left,
    input  logic signed [COORD_BITS-1:0]  req_top,
    input  logic signed [COORD_BITS-1:0]  req_right,
    input  logic signed [COORD_BITS-1:0]  req_bottom,
    output logic                          done,
    output logic signed [COORD_BITS-1:0]  out_left,
    output logic signed [COORD_BITS-1:0]  out_top,
    output logic signed [COORD_BITS-1:0]  out_right,
    output logic signed [COORD_BITS-1:0]  out_bottom,
    output logic                          status
);

    localparam int LAT    = vts_pkg::X_W + 3;
    localparam int PASS_W = 4 * COORD_BITS + 1;

    vts_pkg::cfg_t               cfg;
    logic [vts_pkg::X_W-1:0]     x_left;
    logic [vts_pkg::X_W-1:0]     x_right;
    logic [vts_pkg::X_W-1:0]     x_top;
    logic [vts_pkg::X_W-1:0]     x_bottom;
    logic [vts_pkg::X_W-1:0]     q_left;
    logic [vts_pkg::X_W-1:0]     q_right;
    logic [vts_pkg::X_W-1:0]     q_top;
    logic [vts_pkg::X_W-1:0]     q_bottom;
    logic [vts_pkg::SIZE_W-1:0]  r_left;
    logic [vts_pkg::SIZE_W-1:0]  r_right;
    logic [vts_pkg::SIZE_W-1:0]  r_top;
    logic [vts_pkg::SIZE_W-1:0]  r_bottom;

    logic [LAT-1:0]              vld_reg;
    logic [LAT-1:0]              vld_next;
    logic [PASS_W-1:0]           pass_reg [LAT-1];
    logic [PASS_W-1:0]           pass_tail;
    logic                        accept;

    logic signed [COORD_BITS-1:0] out_left_reg;
    logic signed [COORD_BITS-1:0] out_top_reg;
    logic signed [COORD_BITS-1:0] out_right_reg;
    logic signed [COORD_BITS-1:0] out_bottom_reg;
    logic                         status_reg;

    vts_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vts_prep #(.COORD_BITS(COORD_BITS)) u_prep_x (
        .clk   (clk),
        .lo_in (req_left),
        .hi_in (req_right),
        .lim   (cfg.lim_x),
        .tile  (cfg.tile_x),
        .lo_x  (x_left),
        .hi_x  (x_right)
    );

    vts_prep #(.COORD_BITS(COORD_BITS)) u_prep_y (
        .clk   (clk),
        .lo_in (req_top),
        .hi_in (req_bottom),
        .lim   (cfg.lim_y),
        .tile  (cfg.tile_y),
        .lo_x  (x_top),
        .hi_x  (x_bottom)
    );

    vts_div u_div_left   (.clk(clk), .dividend(x_left),   .divisor(cfg.tile_x), .quotient(q_left));
    vts_div u_div_right  (.clk(clk), .dividend(x_right),  .divisor(cfg.tile_x), .quotient(q_right));
    vts_div u_div_top    (.clk(clk), .dividend(x_top),    .divisor(cfg.tile_y), .quotient(q_top));
    vts_div u_div_bottom (.clk(clk), .dividend(x_bottom), .divisor(cfg.tile_y), .quotient(q_bottom));

    vts_snap u_snap_x (
        .clk    (clk),
        .q_lo   (q_left),
        .q_hi   (q_right),
        .tile   (cfg.tile_x),
        .lim    (cfg.lim_x),
        .lo_res (r_left),
        .hi_res (r_right)
    );

    vts_snap u_snap_y (
        .clk    (clk),
        .q_lo   (q_top),
        .q_hi   (q_bottom),
        .tile   (cfg.tile_y),
        .lim    (cfg.lim_y),
        .lo_res (r_top),
        .hi_res (r_bottom)
    );

    assign busy     = 1'b0;
    assign accept   = start & ~busy;
    assign vld_next = {vld_reg[LAT-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // carry the request and the open flag alongside the datapath
    always_ff @(posedge clk)
    begin
        pass_reg[0] <= {cfg.open, req_left, req_top, req_right, req_bottom};
        for (int i = 1; i < LAT - 1; i++)
        begin
            pass_reg[i] <= pass_reg[i-1];
        end
    end

    assign pass_tail = pass_reg[LAT-2];

    always_ff @(posedge clk)
    begin
        if (vld_reg[LAT-2])
        begin
            if (pass_tail[PASS_W-1])
            begin
                out_left_reg   <= signed'(COORD_BITS'(r_left));
                out_top_reg    <= signed'(COORD_BITS'(r_top));
                out_right_reg  <= signed'(COORD_BITS'(r_right));
                out_bottom_reg <= signed'(COORD_BITS'(r_bottom));
                status_reg     <= 1'b0;
            end
            else
            begin
                out_left_reg   <= signed'(pass_tail[4*COORD_BITS-1:3*COORD_BITS]);
                out_top_reg    <= signed'(pass_tail[3*COORD_BITS-1:2*COORD_BITS]);
                out_right_reg  <= signed'(pass_tail[2*COORD_BITS-1:COORD_BITS]);
                out_bottom_reg <= signed'(pass_tail[COORD_BITS-1:0]);
                status_reg     <= 1'b1;
            end
        end
    end

    assign done       = vld_reg[LAT-1];
    assign out_left   = out_left_reg;
    assign out_top    = out_top_reg;
    assign out_right  = out_right_reg;
    assign out_bottom = out_bottom_reg;
    assign status     = status_reg;

endmodule
